@@ hdl/upd_pkg.sv @@
// package for the url percent decoder: transaction types, escape phase,
// constants and hex helpers; no dependencies
package upd_pkg;

  localparam logic [7:0]  PCT_CHAR        = 8'h25;
  localparam logic [15:0] OUT_LIMIT_RESET = 16'hffff;
  localparam int          QUEUE_DEPTH_DEF = 4;
  localparam int          MAX_RESULTS     = 3;

  typedef struct packed {
    logic [7:0] in_char;
    logic       in_last;
  } upd_in_t;

  typedef struct packed {
    logic [7:0]  out_char;
    logic        out_valid;
    logic        run_last;
    logic        string_done;
    logic [15:0] out_count;
  } upd_out_t;

  // one input byte worth of results, handed from front to back
  typedef struct packed {
    logic [MAX_RESULTS-1:0][7:0] bytes;
    logic [1:0]                  num;
    logic                        has_data;
    logic                        str_end;
    logic [15:0]                 base_count;
  } upd_group_t;

  typedef enum logic [1:0] {
    PH_IDLE  = 2'd0,
    PH_PCT   = 2'd1,
    PH_DIGIT = 2'd2
  } upd_phase_t;

  function automatic logic is_hex(input logic [7:0] c);
    is_hex = (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
             (c >= 8'h61 && c <= 8'h66);
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    if (c <= 8'h39) begin
      hex_val = c[3:0];
    end else begin
      hex_val = c[3:0] + 4'd9;
    end
  endfunction

endpackage

@@ hdl/url_percent_decoder.sv @@
// top level of the url percent decoder
// depends on upd_pkg, upd_front, upd_queue, upd_back
//
// Decodes a percent-encoded string arriving one byte per push transaction,
// with in_last on the final byte. "%hh" (hex, either case) becomes one byte;
// a broken or truncated escape passes through literally. Each input byte
// gives zero to three results on the output queue; a final byte always gives
// at least one (an end marker with out_valid low if nothing else). At most
// out_limit bytes are produced per string; the limit register is written
// through cfg_we/cfg_wdata and resets to 65535. Input bytes are taken one
// per cycle as long as the internal group queue has room (QUEUE_DEPTH
// entries); the output side drains one result per cycle while pop is
// asserted and the queue is not empty, and the sustained rate is set by
// the number of results per byte at the back end.
module url_percent_decoder import upd_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // input side
  input  upd_in_t     in_item,
  input  logic        push,
  output logic        full,
  // result side
  output upd_out_t    out_item,
  output logic        empty,
  input  logic        pop,
  // limit register
  input  logic        cfg_we,
  input  logic [15:0] cfg_wdata
);

  logic [15:0] out_limit;
  logic        accept;
  upd_group_t  front_group, head_group;
  logic        front_push;
  logic        head_done;

  // input transaction taken whenever the queue has room
  assign accept = push && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_limit <= OUT_LIMIT_RESET;
    end else if (cfg_we) begin
      out_limit <= cfg_wdata;
    end
  end

  // escape tracking and limit, one byte per cycle while the queue has room
  upd_front u_front (
    .clk        (clk),
    .rst        (rst),
    .item       (in_item),
    .accept     (accept),
    .out_limit  (out_limit),
    .group      (front_group),
    .group_push (front_push)
  );

  // decouples the byte stream from the result stream
  upd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_group (front_group),
    .wr_en    (front_push),
    .rd_en    (head_done),
    .rd_group (head_group),
    .full     (full),
    .empty    (empty)
  );

  // one result per pop transaction, group retired on its last result
  upd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .group       (head_group),
    .group_avail (!empty),
    .pop         (pop),
    .result      (out_item),
    .group_done  (head_done)
  );

endmodule

@@ hdl/upd_front.sv @@
// front end: escape tracking, candidate bytes and output limit per input byte
// depends on upd_pkg
module upd_front import upd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  upd_in_t    item,
  input  logic       accept,
  input  logic [15:0] out_limit,
  output upd_group_t group,
  output logic       group_push
);

  upd_phase_t  phase, phase_next;
  logic [7:0]  held, held_next;
  logic [15:0] count, count_next;

  logic [3:0][7:0] cand;
  logic [1:0]      ncand;
  logic [15:0]     avail;
  logic [1:0]      k;
  logic [7:0]      c;
  logic            pct;

  always_comb begin
    c          = item.in_char;
    pct        = (c == PCT_CHAR);
    cand       = '0;
    ncand      = 2'd0;
    phase_next = PH_IDLE;
    held_next  = held;
    case (phase)
      PH_PCT: begin
        if (is_hex(c)) begin
          held_next  = c;
          phase_next = PH_DIGIT;
        end else begin
          cand[ncand] = PCT_CHAR;
          ncand = ncand + 2'd1;
          if (pct) begin
            phase_next = PH_PCT;
          end else begin
            cand[ncand] = c;
            ncand = ncand + 2'd1;
          end
        end
      end
      PH_DIGIT: begin
        if (is_hex(c)) begin
          cand[ncand] = {hex_val(held), hex_val(c)};
          ncand = ncand + 2'd1;
        end else begin
          cand[ncand] = PCT_CHAR;
          ncand = ncand + 2'd1;
          cand[ncand] = held;
          ncand = ncand + 2'd1;
          if (pct) begin
            phase_next = PH_PCT;
          end else begin
            cand[ncand] = c;
            ncand = ncand + 2'd1;
          end
        end
      end
      default: begin
        if (pct) begin
          phase_next = PH_PCT;
        end else begin
          cand[ncand] = c;
          ncand = ncand + 2'd1;
        end
      end
    endcase
    // flush a pending escape at end of string
    if (item.in_last) begin
      if (phase_next == PH_PCT) begin
        cand[ncand] = PCT_CHAR;
        ncand = ncand + 2'd1;
      end else if (phase_next == PH_DIGIT) begin
        cand[ncand] = PCT_CHAR;
        ncand = ncand + 2'd1;
        cand[ncand] = held_next;
        ncand = ncand + 2'd1;
      end
      phase_next = PH_IDLE;
      held_next  = 8'h00;
    end

    avail = (out_limit > count) ? (out_limit - count) : 16'd0;
    k     = (avail > {14'd0, ncand}) ? ncand : avail[1:0];

    count_next = item.in_last ? 16'd0 : (count + {14'd0, k});

    group.bytes      = cand[MAX_RESULTS-1:0];
    group.base_count = count;
    group.str_end    = item.in_last;
    group.has_data   = (k != 2'd0);
    group.num        = (k != 2'd0) ? k : 2'd1;
    group_push       = accept && ((k != 2'd0) || item.in_last);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      held  <= 8'h00;
      count <= 16'd0;
    end else if (accept) begin
      phase <= phase_next;
      held  <= held_next;
      count <= count_next;
    end
  end

endmodule

@@ hdl/upd_queue.sv @@
// short register queue of result groups between front and back
// depends on upd_pkg
module upd_queue import upd_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  upd_group_t wr_group,
  input  logic       wr_en,
  input  logic       rd_en,
  output upd_group_t rd_group,
  output logic       full,
  output logic       empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  upd_group_t       store [DEPTH];
  logic [PW-1:0]    wr_ptr, rd_ptr;
  logic [CW-1:0]    fill;
  logic             do_wr, do_rd;

  assign full     = (fill == CW'(DEPTH));
  assign empty    = (fill == '0);
  assign do_wr    = wr_en && !full;
  assign do_rd    = rd_en && !empty;
  assign rd_group = store[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_wr) begin
      store[wr_ptr] <= wr_group;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + PW'(1);
      end
      if (do_rd) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + PW'(1);
      end
      if (do_wr && !do_rd) begin
        fill <= fill + CW'(1);
      end else if (do_rd && !do_wr) begin
        fill <= fill - CW'(1);
      end
    end
  end

endmodule

@@ hdl/upd_back.sv @@
// back end: walks the head group one result per transaction
// depends on upd_pkg
module upd_back import upd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  upd_group_t group,
  input  logic       group_avail,
  input  logic       pop,
  output upd_out_t   result,
  output logic       group_done
);

  logic [1:0] idx;
  logic       at_end;
  logic [7:0] sel_byte;

  assign at_end = (idx == group.num - 2'd1);

  always_comb begin
    case (idx)
      2'd0:    sel_byte = group.bytes[0];
      2'd1:    sel_byte = group.bytes[1];
      2'd2:    sel_byte = group.bytes[2];
      default: sel_byte = 8'h00;
    endcase
    result.out_char    = group.has_data ? sel_byte : 8'h00;
    result.out_valid   = group.has_data;
    result.run_last    = at_end;
    result.string_done = at_end && group.str_end;
    result.out_count   = group.has_data ?
                         (group.base_count + {14'd0, idx} + 16'd1) : group.base_count;
    group_done         = pop && group_avail && at_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= 2'd0;
    end else if (pop && group_avail) begin
      idx <= at_end ? 2'd0 : idx + 2'd1;
    end
  end

endmodule
